// ===== src/erpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Ethernet receive port classifier.
// No dependencies; imported by all modules but erpc_ram.
package erpc_pkg;

  localparam int ADDR_W      = 48;
  localparam int CFG_PORTS   = 2;   // ports that have configuration registers
  localparam int CAM_IDX_W   = 6;   // covers the largest multicast table
  localparam int HDR_BYTES   = 14;
  localparam int LEN_W       = 11;
  localparam int CNT_W       = 32;

  // configuration register indexes
  localparam logic [2:0] REG_STATION_ADDR = 3'd0;
  localparam logic [2:0] REG_PORT0_ADDR   = 3'd1;
  localparam logic [2:0] REG_PORT1_ADDR   = 3'd2;
  localparam logic [2:0] REG_PORT_PROTOS  = 3'd3;
  localparam logic [2:0] REG_PORT_PAD     = 3'd4;
  localparam logic [2:0] REG_PORT_PROMISC = 3'd5;
  localparam logic [2:0] REG_PORT_ENABLE  = 3'd6;

  // result status codes
  localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [2:0] STAT_RUNT      = 3'd1;
  localparam logic [2:0] STAT_OWN_FRAME = 3'd2;
  localparam logic [2:0] STAT_NO_PORT   = 3'd3;
  localparam logic [2:0] STAT_SHORT_PAD = 3'd4;
  localparam logic [2:0] STAT_TBL_WRITE = 3'd5;

  localparam logic [4:0] OFFSET_PLAIN  = 5'd14;
  localparam logic [4:0] OFFSET_PADDED = 5'd16;

  // multicast table write request
  typedef struct packed {
    logic                 en;
    logic [CAM_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    addr;
    logic [CFG_PORTS-1:0] ports;
    logic                 valid;
  } cam_wr_t;

  // one word of the counter memory, one word per port
  typedef struct packed {
    logic [CNT_W-1:0] mc_bytes;
    logic [CNT_W-1:0] mc_pkts;
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] pkts;
  } cnt_word_t;

endpackage

// ===== src/ethernet_rx_port_classifier.sv =====
`timescale 1ns / 1ps
// Ethernet receive port classifier. Each input transfer is either a parsed
// frame header (tuser low) or a multicast table write (tuser high), and gives
// exactly one result transfer. A header is checked for runt length and own
// source, then matched against the enabled ports (protocol, individual
// address, promiscuous flag, multicast table), lowest port first; the
// accepting port's packet, byte and multicast counters are bumped. The accept
// cycle classifies an item and reads the port's counter word from the counter
// memory; the update state then adds and writes it back and loads the output
// register, waiting while the output register holds an untaken result. A new
// item is not taken until the update of the last one is done, since the
// counter memory is read, modified and written back per item. Counters start
// at zero after reset through per-word valid flags, so no clearing pass is
// needed. Depends on erpc_pkg, erpc_ram and erpc_mcast_cam.
module ethernet_rx_port_classifier import erpc_pkg::*; #(
  parameter int NUM_PORTS     = 2,
  parameter int MCAST_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [47:0]  cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_addr[47:0], src_addr[95:48], proto_type[111:96], length_field[127:112],
  // frame_len[138:128], table_index[142:139], table_ports[144:143],
  // table_valid[145], zero fill[151:146]
  input  logic [151:0] s_axis_tdata,
  // op[0]
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], port_index[3], payload_offset[8:4], payload_len[19:9],
  // dest_is_multicast[20], port_pkt_count[52:21], port_byte_count[84:53],
  // zero fill[87:85]
  output logic [87:0]  m_axis_tdata
);

  localparam int ACTIVE_PORTS = (NUM_PORTS < CFG_PORTS) ? NUM_PORTS : CFG_PORTS;
  localparam int CNT_AW       = (ACTIVE_PORTS > 1) ? $clog2(ACTIVE_PORTS) : 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  // ---------------------------------------------------------------- config
  logic [ADDR_W-1:0]    station_q;
  logic [ADDR_W-1:0]    port_addr_q [CFG_PORTS];
  logic [31:0]          protos_q;
  logic [CFG_PORTS-1:0] pad_q, promisc_q, enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q      <= '0;
      port_addr_q[0] <= '0;
      port_addr_q[1] <= '0;
      protos_q       <= '0;
      pad_q          <= '0;
      promisc_q      <= '0;
      enable_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_STATION_ADDR: station_q      <= cfg_wdata_i;
        REG_PORT0_ADDR:   port_addr_q[0] <= cfg_wdata_i;
        REG_PORT1_ADDR:   port_addr_q[1] <= cfg_wdata_i;
        REG_PORT_PROTOS:  protos_q       <= cfg_wdata_i[31:0];
        REG_PORT_PAD:     pad_q          <= cfg_wdata_i[CFG_PORTS-1:0];
        REG_PORT_PROMISC: promisc_q      <= cfg_wdata_i[CFG_PORTS-1:0];
        REG_PORT_ENABLE:  enable_q       <= cfg_wdata_i[CFG_PORTS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  logic              in_op;
  logic [ADDR_W-1:0] in_dest, in_src;
  logic [15:0]       in_proto, in_lenf;
  logic [LEN_W-1:0]  in_flen;
  logic [3:0]        in_tidx;
  logic [1:0]        in_tports;
  logic              in_tvalid;

  assign in_op     = s_axis_tuser;
  assign in_dest   = s_axis_tdata[47:0];
  assign in_src    = s_axis_tdata[95:48];
  assign in_proto  = s_axis_tdata[111:96];
  assign in_lenf   = s_axis_tdata[127:112];
  assign in_flen   = s_axis_tdata[138:128];
  assign in_tidx   = s_axis_tdata[142:139];
  assign in_tports = s_axis_tdata[144:143];
  assign in_tvalid = s_axis_tdata[145];

  logic st_q, st_d;
  logic in_xfer;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- table
  cam_wr_t              cam_wr;
  logic [CFG_PORTS-1:0] cam_hit;

  assign cam_wr.en    = in_xfer && in_op;
  assign cam_wr.idx   = CAM_IDX_W'(in_tidx);
  assign cam_wr.addr  = in_dest;
  assign cam_wr.ports = in_tports;
  assign cam_wr.valid = in_tvalid;

  erpc_mcast_cam #(
    .ENTRIES (MCAST_ENTRIES)
  ) u_cam (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cam_wr),
    .lookup_i (in_dest),
    .hit_o    (cam_hit)
  );

  // ---------------------------------------------------------------- classify
  logic                 own_src;
  logic [CFG_PORTS-1:0] port_hit;
  logic                 sel_port;
  logic                 sel_pad;
  logic                 pad_short;
  logic [2:0]           status_d;
  logic [LEN_W-1:0]     plen_d;

  always_comb begin
    own_src  = (in_src == station_q);
    port_hit = '0;
    for (int p = 0; p < ACTIVE_PORTS; p++) begin
      if (enable_q[p] && (in_src == port_addr_q[p])) begin
        own_src = 1'b1;
      end
      port_hit[p] = enable_q[p] && (protos_q[16*p +: 16] == in_proto) &&
                    (promisc_q[p] || (in_dest == port_addr_q[p]) || cam_hit[p]);
    end
    // lowest matching port wins
    sel_port = 1'b0;
    for (int p = ACTIVE_PORTS - 1; p >= 0; p--) begin
      if (port_hit[p]) begin
        sel_port = 1'(p);
      end
    end
    sel_pad   = pad_q[sel_port];
    pad_short = (17'(in_lenf) + 17'd16) > 17'(in_flen);
    plen_d    = sel_pad ? in_lenf[LEN_W-1:0] : (in_flen - LEN_W'(HDR_BYTES));

    if (in_op) begin
      status_d = STAT_TBL_WRITE;
    end else if (in_flen < LEN_W'(HDR_BYTES)) begin
      status_d = STAT_RUNT;
    end else if (own_src) begin
      status_d = STAT_OWN_FRAME;
    end else if (port_hit == '0) begin
      status_d = STAT_NO_PORT;
    end else if (sel_pad && pad_short) begin
      status_d = STAT_SHORT_PAD;
    end else begin
      status_d = STAT_ACCEPTED;
    end
  end

  // ---------------------------------------------------------------- pending item
  logic [2:0]       pend_status_q;
  logic             pend_port_q;
  logic             pend_pad_q;
  logic [LEN_W-1:0] pend_plen_q;
  logic             pend_mc_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_status_q <= status_d;
      pend_port_q   <= sel_port;
      pend_pad_q    <= sel_pad;
      pend_plen_q   <= plen_d;
      pend_mc_q     <= in_dest[40];
    end
  end

  // ---------------------------------------------------------------- counters
  // The write back is in the update state and the next read only in the idle
  // state after it, so no forwarding path is needed.
  logic                    out_free;
  logic                    upd_go;
  logic                    cnt_wr_en;
  cnt_word_t               cnt_rd, cnt_old, cnt_new;
  logic [ACTIVE_PORTS-1:0] cnt_vld_q;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign upd_go    = (st_q == ST_UPDATE) && out_free;
  assign cnt_wr_en = upd_go && (pend_status_q == STAT_ACCEPTED);

  erpc_ram #(
    .WIDTH ($bits(cnt_word_t)),
    .DEPTH (ACTIVE_PORTS)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cnt_wr_en),
    .wr_addr_i (CNT_AW'(pend_port_q)),
    .wr_data_i (cnt_new),
    .rd_en_i   (in_xfer),
    .rd_addr_i (CNT_AW'(sel_port)),
    .rd_data_o (cnt_rd)
  );

  always_comb begin
    cnt_old = cnt_vld_q[CNT_AW'(pend_port_q)] ? cnt_rd : '0;
    cnt_new = cnt_old;
    cnt_new.pkts  = cnt_old.pkts + 32'd1;
    cnt_new.bytes = cnt_old.bytes + 32'(pend_plen_q);
    if (pend_mc_q) begin
      cnt_new.mc_pkts  = cnt_old.mc_pkts + 32'd1;
      cnt_new.mc_bytes = cnt_old.mc_bytes + 32'(pend_plen_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_wr_en) begin
      cnt_vld_q[CNT_AW'(pend_port_q)] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- result
  logic [87:0] out_data_d, out_data_q;
  logic        out_valid_q;

  always_comb begin
    case (pend_status_q)
      STAT_ACCEPTED: begin
        out_data_d = {3'd0, cnt_new.bytes, cnt_new.pkts, pend_mc_q, pend_plen_q,
                      (pend_pad_q ? OFFSET_PADDED : OFFSET_PLAIN),
                      pend_port_q, pend_status_q};
      end
      STAT_TBL_WRITE: begin
        out_data_d = {85'd0, pend_status_q};
      end
      default: begin
        out_data_d = {67'd0, pend_mc_q, LEN_W'(0), OFFSET_PLAIN, 1'b0, pend_status_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (in_xfer) st_d = ST_UPDATE;
      ST_UPDATE: if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ===== src/erpc_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module erpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                     wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                     rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/erpc_mcast_cam.sv =====
`timescale 1ns / 1ps
// Multicast address table: per-entry registers with a parallel compare.
// Depends on erpc_pkg.
module erpc_mcast_cam import erpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cam_wr_t              wr_i,
  input  logic [ADDR_W-1:0]    lookup_i,
  output logic [CFG_PORTS-1:0] hit_o
);

  logic [ADDR_W-1:0]    addr_q  [ENTRIES];
  logic [CFG_PORTS-1:0] mask_q  [ENTRIES];
  logic [ENTRIES-1:0]   valid_q;

  // writes to an index beyond the table match no entry and fall away
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_i.en && (wr_i.idx == CAM_IDX_W'(i))) begin
          valid_q[i] <= wr_i.valid;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_i.en && (wr_i.idx == CAM_IDX_W'(i))) begin
        addr_q[i] <= wr_i.addr;
        mask_q[i] <= wr_i.ports;
      end
    end
  end

  always_comb begin
    hit_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && (addr_q[i] == lookup_i)) begin
        hit_o = hit_o | mask_q[i];
      end
    end
  end

endmodule

// ===== src/erpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the receive port classifier, bound to its top level.
// Depends on erpc_pkg and ethernet_rx_port_classifier.
module erpc_checker import erpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  logic [2:0]  status;
  logic [4:0]  offset;
  logic [63:0] counts;
  logic [10:0] plen;

  assign status = m_axis_tdata[2:0];
  assign offset = m_axis_tdata[8:4];
  assign plen   = m_axis_tdata[19:9];
  assign counts = m_axis_tdata[84:21];

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status <= STAT_TBL_WRITE))
    else $error("undefined status code");

  a_tbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == STAT_TBL_WRITE) |-> (m_axis_tdata[87:3] == '0))
    else $error("table write result carries data");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != STAT_ACCEPTED) && (status != STAT_TBL_WRITE) |->
      (counts == '0) && (plen == '0) && (offset == OFFSET_PLAIN))
    else $error("dropped frame reports counts or payload");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == STAT_ACCEPTED) |->
      ((offset == OFFSET_PLAIN) || (offset == OFFSET_PADDED)) && (counts[31:0] != '0))
    else $error("accepted frame with bad offset or zero packet count");

endmodule

bind ethernet_rx_port_classifier erpc_checker u_erpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/ethernet_rx_port_classifier_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Ethernet receive port classifier: a queue-fed stream
// driver, a result monitor and an in-bench classifier that predicts every result.
// Depends on erpc_pkg and the ethernet_rx_port_classifier RTL.
module ethernet_rx_port_classifier_test;
  import erpc_pkg::*;

  localparam int N_PORTS     = 2;
  localparam int MCAST_N     = 16;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [15:0]       proto;
    logic [15:0]       lenf;
    logic [LEN_W-1:0]  flen;
    logic [3:0]        tidx;
    logic [1:0]        tports;
    logic              tvalid;
  } frame_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             port_index;
    logic [4:0]       payload_offset;
    logic [LEN_W-1:0] payload_len;
    logic             dest_mc;
    logic [CNT_W-1:0] pkt_count;
    logic [CNT_W-1:0] byte_count;
  } class_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [47:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  ethernet_rx_port_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // configuration copy
  logic [ADDR_W-1:0] cfg_station;
  logic [ADDR_W-1:0] cfg_port_addr [N_PORTS];
  logic [31:0]       cfg_protos;
  logic [1:0]        cfg_pad;
  logic [1:0]        cfg_promisc;
  logic [1:0]        cfg_enable;

  // multicast table and per-port counters
  logic [ADDR_W-1:0] tbl_addr  [MCAST_N];
  logic [1:0]        tbl_ports [MCAST_N];
  logic              tbl_valid [MCAST_N];
  logic [CNT_W-1:0]  pkt_cnt     [N_PORTS];
  logic [CNT_W-1:0]  byte_cnt    [N_PORTS];
  logic [CNT_W-1:0]  mc_pkt_cnt  [N_PORTS];
  logic [CNT_W-1:0]  mc_byte_cnt [N_PORTS];

  logic [ADDR_W-1:0] mc_pool [4];

  frame_item_t   pending_frames[$];
  class_result_t expected_results[$];
  int            offered_frames = 0;
  int            accepted_frames = 0;
  int            mismatch_cnt = 0;
  bit            calm_phase = 1'b0;

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  function automatic void queue_frame(frame_item_t it);
    pending_frames = {pending_frames, it};
  endfunction

  function automatic bit port_takes(int p, logic [ADDR_W-1:0] dest);
    if (cfg_promisc[p]) return 1'b1;
    if (dest == cfg_port_addr[p]) return 1'b1;
    for (int i = 0; i < MCAST_N; i++)
      if (tbl_valid[i] && tbl_addr[i] == dest && tbl_ports[i][p]) return 1'b1;
    return 1'b0;
  endfunction

  // Classify one transfer and advance the table and counters as the block does.
  function automatic class_result_t predict_result(frame_item_t it);
    class_result_t r;
    logic [LEN_W-1:0] plen;
    r = '0;
    r.payload_offset = OFFSET_PLAIN;
    if (it.op) begin
      r.status = STAT_TBL_WRITE;
      r.payload_offset = '0;
      if (it.tidx < MCAST_N) begin
        tbl_addr[it.tidx]  = it.dest;
        tbl_ports[it.tidx] = it.tports;
        tbl_valid[it.tidx] = it.tvalid;
      end
      return r;
    end
    r.dest_mc = it.dest[40];
    if (it.flen < HDR_BYTES) begin
      r.status = STAT_RUNT;
      return r;
    end
    if (it.src == cfg_station) begin
      r.status = STAT_OWN_FRAME;
      return r;
    end
    for (int p = 0; p < N_PORTS; p++)
      if (cfg_enable[p] && it.src == cfg_port_addr[p]) begin
        r.status = STAT_OWN_FRAME;
        return r;
      end
    for (int p = 0; p < N_PORTS; p++) begin
      if (!cfg_enable[p]) continue;
      if (cfg_protos[16*p +: 16] != it.proto) continue;
      if (!port_takes(p, it.dest)) continue;
      if (cfg_pad[p]) begin
        if (32'd16 + it.lenf > it.flen) begin
          r.status = STAT_SHORT_PAD;
          return r;
        end
        plen = it.lenf[LEN_W-1:0];
        r.payload_offset = OFFSET_PADDED;
      end else begin
        plen = it.flen - LEN_W'(HDR_BYTES);
      end
      pkt_cnt[p]  = pkt_cnt[p] + 1;
      byte_cnt[p] = byte_cnt[p] + plen;
      if (it.dest[40]) begin
        mc_pkt_cnt[p]  = mc_pkt_cnt[p] + 1;
        mc_byte_cnt[p] = mc_byte_cnt[p] + plen;
      end
      r.status      = STAT_ACCEPTED;
      r.port_index  = p[0];
      r.payload_len = plen;
      r.pkt_count   = pkt_cnt[p];
      r.byte_count  = byte_cnt[p];
      return r;
    end
    r.status = STAT_NO_PORT;
    return r;
  endfunction

  function automatic frame_item_t mk_frame(logic [ADDR_W-1:0] dest, logic [ADDR_W-1:0] src,
                                           logic [15:0] proto, logic [15:0] lenf,
                                           logic [LEN_W-1:0] flen);
    frame_item_t it;
    it = '0;
    it.dest  = dest;
    it.src   = src;
    it.proto = proto;
    it.lenf  = lenf;
    it.flen  = flen;
    return it;
  endfunction

  function automatic frame_item_t mk_table(logic [3:0] idx, logic [ADDR_W-1:0] addr,
                                           logic [1:0] ports, logic valid);
    frame_item_t it;
    it = '0;
    it.op     = 1'b1;
    it.dest   = addr;
    it.tidx   = idx;
    it.tports = ports;
    it.tvalid = valid;
    return it;
  endfunction

  // Mostly frames that reach the port match: known protocols, addresses and table hits.
  function automatic frame_item_t random_frame();
    frame_item_t it;
    int p;
    it.op     = ($urandom_range(0, 9) == 0);
    it.dest   = rand_addr();
    it.src    = rand_addr();
    it.proto  = 16'($urandom);
    it.lenf   = 16'($urandom);
    it.flen   = LEN_W'($urandom);
    it.tidx   = 4'($urandom);
    it.tports = 2'($urandom);
    it.tvalid = 1'($urandom);
    if (it.op) begin
      if ($urandom_range(0, 3) != 0) it.dest = mc_pool[$urandom_range(0, 3)];
      it.tvalid = ($urandom_range(0, 3) != 0);
      return it;
    end
    p = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0:       it.flen = LEN_W'($urandom_range(0, HDR_BYTES - 1));
      1:       it.flen = LEN_W'($urandom_range(HDR_BYTES, HDR_BYTES + 3));
      default: it.flen = LEN_W'($urandom_range(HDR_BYTES, 2047));
    endcase
    if ($urandom_range(0, 3) != 0) it.proto = cfg_protos[16*p +: 16];
    case ($urandom_range(0, 5))
      0:       it.dest = cfg_port_addr[0];
      1:       it.dest = cfg_port_addr[1];
      2, 3:    it.dest = mc_pool[$urandom_range(0, 3)];
      4:       it.dest = '1;
      default: ;
    endcase
    case ($urandom_range(0, 19))
      0:       it.src = cfg_station;
      1:       it.src = cfg_port_addr[0];
      2:       it.src = cfg_port_addr[1];
      default: ;
    endcase
    // aim the length word at the short-padding boundary
    if (it.flen >= 16 && $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0:       it.lenf = 16'(it.flen - 16);
        1:       it.lenf = 16'(it.flen - 15);
        default: it.lenf = 16'($urandom_range(0, it.flen - 16));
      endcase
    end
    return it;
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    case (idx)
      REG_STATION_ADDR: cfg_station      = val;
      REG_PORT0_ADDR:   cfg_port_addr[0] = val;
      REG_PORT1_ADDR:   cfg_port_addr[1] = val;
      REG_PORT_PROTOS:  cfg_protos       = val[31:0];
      REG_PORT_PAD:     cfg_pad          = val[1:0];
      REG_PORT_PROMISC: cfg_promisc      = val[1:0];
      REG_PORT_ENABLE:  cfg_enable       = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic apply_config(input logic [47:0] station, input logic [47:0] a0,
                              input logic [47:0] a1, input logic [31:0] protos,
                              input logic [1:0] pad, input logic [1:0] promisc,
                              input logic [1:0] enable);
    set_reg(REG_STATION_ADDR, station);
    set_reg(REG_PORT0_ADDR, a0);
    set_reg(REG_PORT1_ADDR, a1);
    set_reg(REG_PORT_PROTOS, {16'd0, protos});
    set_reg(REG_PORT_PAD, {46'd0, pad});
    set_reg(REG_PORT_PROMISC, {46'd0, promisc});
    set_reg(REG_PORT_ENABLE, {46'd0, enable});
  endtask

  task automatic random_config();
    logic [31:0] protos;
    protos = $urandom;
    if ($urandom_range(0, 2) == 0) protos[31:16] = protos[15:0];
    apply_config(rand_addr(), rand_addr(), rand_addr(), protos, 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), 2'($urandom_range(1, 3)));
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_frames.size() != 0 || offered_frames != accepted_frames ||
           expected_results.size() != 0);
  endtask

  task automatic random_phase(input int n);
    repeat (n) queue_frame(random_frame());
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Stream driver: hold a transfer until taken, then idle or offer the next one.
  always @(negedge clk_i) begin : driver
    frame_item_t it;
    bit drain_hold;
    if (rst_ni && !(s_axis_tvalid && offered_frames != accepted_frames)) begin
      if (!drain_hold && pending_frames.size() != 0 && $urandom_range(1, 200) == 1)
        drain_hold = 1'b1;
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
      if (pending_frames.size() != 0 && !drain_hold &&
          (calm_phase || $urandom_range(0, 99) >= 26)) begin
        it = pending_frames.pop_front();
        s_axis_tdata  <= {6'd0, it.tvalid, it.tports, it.tidx, it.flen, it.lenf,
                          it.proto, it.src, it.dest};
        s_axis_tuser  <= it.op;
        s_axis_tvalid <= 1'b1;
        offered_frames++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= 26);

  always @(posedge clk_i) begin : monitor
    frame_item_t   it;
    class_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no frame outstanding");
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
          check_field("port_index", 32'(want.port_index), 32'(m_axis_tdata[3]));
          check_field("payload_offset", 32'(want.payload_offset), 32'(m_axis_tdata[8:4]));
          check_field("payload_len", 32'(want.payload_len), 32'(m_axis_tdata[19:9]));
          check_field("dest_is_multicast", 32'(want.dest_mc), 32'(m_axis_tdata[20]));
          check_field("port_pkt_count", want.pkt_count, m_axis_tdata[52:21]);
          check_field("port_byte_count", want.byte_count, m_axis_tdata[84:53]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.op     = s_axis_tuser;
        it.dest   = s_axis_tdata[47:0];
        it.src    = s_axis_tdata[95:48];
        it.proto  = s_axis_tdata[111:96];
        it.lenf   = s_axis_tdata[127:112];
        it.flen   = s_axis_tdata[138:128];
        it.tidx   = s_axis_tdata[142:139];
        it.tports = s_axis_tdata[144:143];
        it.tvalid = s_axis_tdata[145];
        expected_results = {expected_results, predict_result(it)};
        accepted_frames++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [47:0] sta, a0, a1, other, mc_a, mc_b, ucast;
    sta   = 48'h02_00_00_00_00_01;
    a0    = 48'h02_00_00_00_00_10;
    a1    = 48'h02_00_00_00_00_20;
    other = 48'h0a_00_00_00_00_99;
    mc_a  = 48'h01_00_5e_00_00_01;
    mc_b  = 48'h03_00_00_00_00_02;
    ucast = 48'h00_00_11_22_33_44;
    cfg_station = '0;
    cfg_protos  = '0;
    cfg_pad     = '0;
    cfg_promisc = '0;
    cfg_enable  = '0;
    for (int p = 0; p < N_PORTS; p++) begin
      cfg_port_addr[p] = '0;
      pkt_cnt[p]       = '0;
      byte_cnt[p]      = '0;
      mc_pkt_cnt[p]    = '0;
      mc_byte_cnt[p]   = '0;
    end
    for (int i = 0; i < MCAST_N; i++) begin
      tbl_addr[i]  = '0;
      tbl_ports[i] = '0;
      tbl_valid[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      mc_pool[i]     = rand_addr();
      mc_pool[i][40] = 1'b1;
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // port 0 padded, port 1 plain
    apply_config(sta, a0, a1, {16'h6004, 16'h6003}, 2'b01, 2'b00, 2'b11);
    queue_frame(mk_frame(a0, other, 16'h6003, 16'd0, 11'd0));
    queue_frame(mk_frame(mc_a, other, 16'h6003, 16'd0, 11'd13));
    queue_frame(mk_frame(a1, other, 16'h6004, 16'd0, 11'd14));
    queue_frame(mk_frame(a1, other, 16'h6004, 16'hffff, 11'd2047));
    queue_frame(mk_frame(a1, sta, 16'h6004, 16'd0, 11'd60));
    queue_frame(mk_frame(a1, a0, 16'h6004, 16'd0, 11'd60));
    queue_frame(mk_frame(a0, a1, 16'h6003, 16'd0, 11'd60));
    queue_frame(mk_frame(a0, other, 16'h1234, 16'd0, 11'd60));
    queue_frame(mk_frame(a0, other, 16'h6003, 16'd100, 11'd200));
    queue_frame(mk_frame(a0, other, 16'h6003, 16'd185, 11'd200));
    queue_frame(mk_frame(a0, other, 16'h6003, 16'd184, 11'd200));
    queue_frame(mk_frame(a0, other, 16'h6003, 16'hffff, 11'd2047));
    queue_frame(mk_table(4'd0, mc_a, 2'b01, 1'b1));
    queue_frame(mk_frame(mc_a, other, 16'h6003, 16'd10, 11'd64));
    queue_frame(mk_table(4'd15, mc_b, 2'b10, 1'b1));
    queue_frame(mk_frame(mc_b, other, 16'h6003, 16'd10, 11'd64));
    queue_frame(mk_frame(mc_b, other, 16'h6004, 16'd10, 11'd64));
    queue_frame(mk_table(4'd0, mc_a, 2'b01, 1'b0));
    queue_frame(mk_frame(mc_a, other, 16'h6003, 16'd10, 11'd64));
    queue_frame(mk_table(4'd7, ucast, 2'b11, 1'b1));
    queue_frame(mk_frame(ucast, other, 16'h6004, 16'd0, 11'd80));
    queue_frame(mk_frame('1, '1, 16'h6004, 16'd0, 11'd60));
    wait_drained();

    // same protocol on both ports: the lower port wins
    apply_config(sta, a0, a1, {16'h0800, 16'h0800}, 2'b00, 2'b11, 2'b11);
    queue_frame(mk_frame(other, other, 16'h0800, 16'd0, 11'd100));
    wait_drained();
    set_reg(REG_PORT_PROMISC, 48'd2);
    queue_frame(mk_frame(other, other, 16'h0800, 16'd0, 11'd100));
    wait_drained();
    // a disabled port's address is not an own source
    set_reg(REG_PORT_ENABLE, 48'd2);
    queue_frame(mk_frame(other, a0, 16'h0800, 16'd0, 11'd100));
    wait_drained();

    apply_config('0, '0, '0, '0, 2'b00, 2'b00, 2'b00);
    random_phase(100);
    apply_config('1, '1, '1, '1, 2'b11, 2'b11, 2'b11);
    random_phase(100);
    for (int k = 0; k < 6; k++) begin
      random_config();
      calm_phase = (k == 2);
      random_phase(170);
      calm_phase = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
